@@ design/assert_macros.svh @@
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must hold on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/slil_pkg.sv @@
// Types and constants for the sorted insertion list.
package slil_pkg;

    localparam int KEY_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REVERSE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic signed [KEY_W-1:0] key;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [COUNT_W-1:0]      count;
        logic signed [KEY_W-1:0] first_entry;
        logic signed [KEY_W-1:0] last_entry;
    } t_resp;

    // Command broadcast to every cell.
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic                    rev;
        logic signed [KEY_W-1:0] key;
    } t_cell_cmd;

    // Match flags rippling between neighboring cells.
    typedef struct packed {
        logic gt;
        logic eq;
    } t_chain;

endpackage

@@ design/sorted_list_insert_delete_core.sv @@
// Top level of the sorted insertion list: a chain of cells plus count and readout.
//
// A request (func, key) is taken on a clock edge with start high and busy low.
// Insert places the key before the first entry greater than it, or at the end;
// a full list drops the key (status full). Delete removes the first equal entry
// or reports not found. Reverse mirrors the list order.
// The request updates every cell at once on the accepting edge; the front and
// rear entries are gathered from the cells in the following cycle.
// o_strobe, registered through r_pend and then r_strobe, is high for one cycle,
// carrying status, count, first and last entry; the receiver has no way to stall it.
// busy is high in the cycle after acceptance, so no new request is taken while
// the readout of the last one is gathered.
// Reset (synchronous, active low) empties the list and clears the order flag;
// entry storage is not cleared and holds no meaning until written.
module sorted_list_insert_delete_core import slil_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_req  i_req,
    output logic  o_strobe,
    output t_resp o_resp
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic [OCC_W-1:0]        r_occ;
    logic                    r_rev;
    logic                    r_pend;
    logic [STATUS_W-1:0]     r_status;
    logic                    r_strobe;
    t_resp                   r_resp;

    logic                    accept;
    logic                    full;
    logic                    found;
    t_cell_cmd               cmd;
    logic [STATUS_W-1:0]     n_status;
    logic [OCC_W-1:0]        n_occ;
    logic signed [KEY_W-1:0] head;
    logic signed [KEY_W-1:0] tail;

    logic signed [KEY_W-1:0] w_data [CAPACITY];
    t_chain                  w_up   [CAPACITY];
    t_chain                  w_dn   [CAPACITY];
    logic [CAPACITY-1:0]     w_hold;

    assign accept = start && !busy;
    assign busy   = r_pend;
    assign full   = (r_occ == OCC_W'(CAPACITY));
    assign found  = w_up[CAPACITY-1].eq | w_dn[0].eq;

    always_comb begin
        cmd.ins = accept && (i_req.func == FUNC_INSERT) && !full;
        cmd.del = accept && (i_req.func == FUNC_DELETE);
        cmd.rev = r_rev;
        cmd.key = i_req.key;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_chain                  from_lower;
        t_chain                  from_upper;
        logic                    hold_prev;
        logic signed [KEY_W-1:0] lower_data;
        logic signed [KEY_W-1:0] upper_data;

        if (i == 0) begin : g_first
            assign from_lower = '0;
            assign hold_prev  = 1'b1;
            assign lower_data = w_data[0];
        end else begin : g_mid
            assign from_lower = w_up[i-1];
            assign hold_prev  = w_hold[i-1];
            assign lower_data = w_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign from_upper = '0;
            assign upper_data = w_data[i];
        end else begin : g_inner
            assign from_upper = w_dn[i+1];
            assign upper_data = w_data[i+1];
        end

        slil_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cmd),
            .i_valid      (OCC_W'(i) < r_occ),
            .i_hold_prev  (hold_prev),
            .i_from_lower (from_lower),
            .i_from_upper (from_upper),
            .i_lower_data (lower_data),
            .i_upper_data (upper_data),
            .o_to_upper   (w_up[i]),
            .o_to_lower   (w_dn[i]),
            .o_hold       (w_hold[i]),
            .o_data       (w_data[i])
        );
    end

    always_comb begin
        n_status = STATUS_DONE;
        n_occ    = r_occ;
        case (i_req.func)
            FUNC_INSERT: begin
                if (full) begin
                    n_status = STATUS_FULL;
                end else begin
                    n_occ = r_occ + OCC_W'(1);
                end
            end
            FUNC_DELETE: begin
                if (found) begin
                    n_occ = r_occ - OCC_W'(1);
                end else begin
                    n_status = STATUS_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        head = (r_occ != '0) ? w_data[0] : '0;
        tail = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            tail = tail | (w_data[i] & {KEY_W{(OCC_W'(i + 1) == r_occ)}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_rev    <= 1'b0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_pend   <= accept;
            r_strobe <= r_pend;
            if (accept) begin
                r_occ <= n_occ;
                if (i_req.func == FUNC_REVERSE) begin
                    r_rev <= !r_rev;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
        end
        if (r_pend) begin
            r_resp.status      <= r_status;
            r_resp.count       <= COUNT_W'(r_occ);
            r_resp.first_entry <= r_rev ? tail : head;
            r_resp.last_entry  <= r_rev ? head : tail;
        end
    end

    assign o_strobe = r_strobe;
    assign o_resp   = r_resp;

    `include "assert_macros.svh"

    `ASSERT_CLK(a_occ_bound, i_clk, i_rst_n, r_occ <= OCC_W'(CAPACITY), "occupancy beyond capacity")
    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, accept |=> busy, "busy missing after request")
    `ASSERT_CLK(a_strobe_latency, i_clk, i_rst_n, accept |=> ##1 o_strobe, "result strobe late")
    `ASSERT_CLK(a_count_match, i_clk, i_rst_n, o_strobe |-> (o_resp.count == COUNT_W'(r_occ)), "count mismatch")

endmodule

@@ design/slil_cell.sv @@
// One list cell: holds one entry, compares it and shifts with its neighbors.
module slil_cell import slil_pkg::*; (
    input  logic                    i_clk,
    input  t_cell_cmd               i_cmd,
    input  logic                    i_valid,
    input  logic                    i_hold_prev,
    input  t_chain                  i_from_lower,
    input  t_chain                  i_from_upper,
    input  logic signed [KEY_W-1:0] i_lower_data,
    input  logic signed [KEY_W-1:0] i_upper_data,
    output t_chain                  o_to_upper,
    output t_chain                  o_to_lower,
    output logic                    o_hold,
    output logic signed [KEY_W-1:0] o_data
);

    logic signed [KEY_W-1:0] r_data;
    logic signed [KEY_W-1:0] n_data;
    logic                    gt;
    logic                    eq;
    logic                    found;
    logic                    shift_down;

    always_comb begin
        gt = i_valid && (i_cmd.key < r_data);
        eq = i_valid && (r_data == i_cmd.key);

        o_to_upper.gt = i_from_lower.gt | gt;
        o_to_upper.eq = i_from_lower.eq | eq;
        o_to_lower.gt = i_from_upper.gt | gt;
        o_to_lower.eq = i_from_upper.eq | eq;

        // hold: this cell sits before the insert slot in physical order
        o_hold = i_cmd.rev ? (i_from_upper.gt | gt) : (i_valid && !(i_from_lower.gt | gt));

        found      = i_from_lower.eq | eq | i_from_upper.eq;
        shift_down = i_cmd.rev ? (found && !i_from_upper.eq) : (i_from_lower.eq | eq);

        n_data = r_data;
        if (i_cmd.ins) begin
            if (!o_hold) begin
                n_data = i_hold_prev ? i_cmd.key : i_lower_data;
            end
        end else if (i_cmd.del) begin
            if (shift_down) begin
                n_data = i_upper_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ tb/sv/slil_checker.sv @@
`timescale 1ns / 100ps
// Request/response checker for the sorted insertion list: predicts each response and compares it.
module slil_checker import slil_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_busy,
    input  t_req  i_req,
    input  logic  i_strobe,
    input  t_resp i_resp,
    output int    o_fail_count,
    output int    o_pending
);

    logic signed [KEY_W-1:0] list_keys [CAPACITY];
    int                      list_len = 0;
    int                      fail_total = 0;
    t_resp                   resp_due [$];
    t_resp                   exp_resp;

    function automatic t_resp apply_request(input t_req r);
        t_resp                   rsp;
        int                      pos;
        int                      i;
        logic                    hit;
        logic signed [KEY_W-1:0] tmp;
        rsp = '0;
        rsp.status = STATUS_DONE;
        case (r.func)
            FUNC_INSERT: begin
                if (list_len >= CAPACITY) begin
                    rsp.status = STATUS_FULL;
                end else begin
                    pos = list_len;
                    for (i = list_len - 1; i >= 0; i--) begin
                        if (r.key < list_keys[i]) pos = i;
                    end
                    for (i = list_len; i > pos; i--) list_keys[i] = list_keys[i-1];
                    list_keys[pos] = r.key;
                    list_len++;
                end
            end
            FUNC_DELETE: begin
                hit = 1'b0;
                pos = 0;
                for (i = 0; i < list_len; i++) begin
                    if (!hit && list_keys[i] == r.key) begin
                        hit = 1'b1;
                        pos = i;
                    end
                end
                if (hit) begin
                    for (i = pos; i < list_len - 1; i++) list_keys[i] = list_keys[i+1];
                    list_len--;
                end else begin
                    rsp.status = STATUS_NOT_FOUND;
                end
            end
            FUNC_REVERSE: begin
                for (i = 0; i < list_len / 2; i++) begin
                    tmp = list_keys[i];
                    list_keys[i] = list_keys[list_len-1-i];
                    list_keys[list_len-1-i] = tmp;
                end
            end
            default: ;
        endcase
        rsp.count = COUNT_W'(list_len);
        if (list_len > 0) begin
            rsp.first_entry = list_keys[0];
            rsp.last_entry  = list_keys[list_len-1];
        end
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            resp_due.delete();
        end else begin
            if (i_strobe) begin
                if (resp_due.size() == 0) begin
                    $error("response with no request outstanding");
                    fail_total++;
                end else begin
                    exp_resp = resp_due.pop_front();
                    if (i_resp.status !== exp_resp.status) begin
                        $error("status: expected %0d, got %0d", exp_resp.status, i_resp.status);
                        fail_total++;
                    end
                    if (i_resp.count !== exp_resp.count) begin
                        $error("count: expected %0d, got %0d", exp_resp.count, i_resp.count);
                        fail_total++;
                    end
                    if (i_resp.first_entry !== exp_resp.first_entry) begin
                        $error("first_entry: expected %0d, got %0d",
                               exp_resp.first_entry, i_resp.first_entry);
                        fail_total++;
                    end
                    if (i_resp.last_entry !== exp_resp.last_entry) begin
                        $error("last_entry: expected %0d, got %0d",
                               exp_resp.last_entry, i_resp.last_entry);
                        fail_total++;
                    end
                end
            end
            if (i_start && !i_busy) resp_due.push_back(apply_request(i_req));
        end
        o_fail_count <= fail_total;
        o_pending    <= resp_due.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Top of the sorted insertion list testbench: clock, reset, request stimulus and verdict.
module tb import slil_pkg::*; ();

    localparam int CAPACITY  = 16;
    localparam int N_RANDOM  = 1300;
    localparam int N_RECENT  = 8;
    localparam logic [FUNC_W-1:0]       FUNC_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MAX     = 32'sh7fff_ffff;
    localparam logic signed [KEY_W-1:0] KEY_MIN     = 32'sh8000_0000;

    logic  i_clk = 1'b0;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_strobe;
    t_resp o_resp;
    int    fail_count;
    int    pending;

    logic signed [KEY_W-1:0] recent_keys [N_RECENT];
    int                      recent_wr = 0;

    always #1 i_clk = ~i_clk;

    sorted_list_insert_delete_core #(.CAPACITY(CAPACITY)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_resp   (o_resp)
    );

    slil_checker #(.CAPACITY(CAPACITY)) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_resp       (o_resp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key(input bit for_delete);
        int r;
        r = $urandom_range(0, 99);
        if (for_delete && r < 50) return recent_keys[$urandom_range(0, N_RECENT-1)];
        r = $urandom_range(0, 99);
        if (r < 55) return KEY_W'(int'($urandom_range(0, 15)) - 8);
        if (r < 65) begin
            case ($urandom_range(0, 3))
                0:       return KEY_MAX;
                1:       return KEY_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    task automatic issue(input logic [FUNC_W-1:0] op, input logic signed [KEY_W-1:0] key,
                         input int gap);
        i_req <= '{func: op, key: key};
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if (op == FUNC_INSERT) begin
            recent_keys[recent_wr] = key;
            recent_wr = (recent_wr + 1) % N_RECENT;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic random_request(input int mode, input bit no_idle);
        int                  r;
        int                  ins_pct;
        int                  del_pct;
        logic [FUNC_W-1:0]   op;
        r = $urandom_range(0, 99);
        case (mode)
            0:       begin ins_pct = 70; del_pct = 85; end
            1:       begin ins_pct = 30; del_pct = 85; end
            default: begin ins_pct = 45; del_pct = 85; end
        endcase
        if (r < ins_pct)      op = FUNC_INSERT;
        else if (r < del_pct) op = FUNC_DELETE;
        else if (r < 97)      op = FUNC_REVERSE;
        else                  op = FUNC_UNUSED;
        issue(op, op == FUNC_DELETE ? pick_key(1'b1) : pick_key(1'b0),
              no_idle ? 0 : pick_gap());
    endtask

    initial begin
        int sent;
        int burst_len;
        int mode;
        bit no_idle;
        int i;
        for (i = 0; i < N_RECENT; i++) recent_keys[i] = '0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_req   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list and short list corner cases
        issue(FUNC_DELETE,  '0,      pick_gap());
        issue(FUNC_REVERSE, '0,      pick_gap());
        issue(FUNC_UNUSED,  '0,      pick_gap());
        issue(FUNC_INSERT,  KEY_MAX, pick_gap());
        issue(FUNC_REVERSE, '0,      pick_gap());
        issue(FUNC_DELETE,  KEY_MAX, pick_gap());
        issue(FUNC_INSERT,  KEY_MAX, pick_gap());
        issue(FUNC_INSERT,  KEY_MIN, pick_gap());
        issue(FUNC_INSERT,  '0,      pick_gap());
        issue(FUNC_INSERT,  '1,      pick_gap());
        issue(FUNC_INSERT,  '0,      pick_gap());
        issue(FUNC_DELETE,  '0,      pick_gap());
        issue(FUNC_DELETE,  32'sd5,  pick_gap());
        issue(FUNC_REVERSE, KEY_MAX, pick_gap());
        issue(FUNC_INSERT,  32'sd1,  pick_gap());
        issue(FUNC_UNUSED,  KEY_MIN, pick_gap());
        // fill to capacity, then overflow
        for (i = 5; i < CAPACITY; i++) begin
            issue(FUNC_INSERT, 32'sh5555_5555 ^ KEY_W'(i * 32'h0101_0101), 0);
        end
        issue(FUNC_INSERT,  32'sh2aaa_aaaa, pick_gap());
        issue(FUNC_DELETE,  KEY_MIN, pick_gap());
        drain();

        sent = 0;
        while (sent < N_RANDOM) begin
            burst_len = $urandom_range(20, 60);
            mode      = $urandom_range(0, 2);
            no_idle   = ($urandom_range(0, 3) == 0);
            for (i = 0; i < burst_len && sent < N_RANDOM; i++) begin
                random_request(mode, no_idle);
                sent++;
                if (sent == N_RANDOM / 2) drain();
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ sorted_list_insert_delete_core.f @@
+incdir+design
design/slil_pkg.sv
design/slil_cell.sv
design/sorted_list_insert_delete_core.sv
tb/sv/slil_checker.sv
tb/sv/tb.sv
